FILE: design/assert_macros.svh
// Assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/stkf_pkg.sv
// Package: constants and types of the top-k frequency tracker
package stkf_pkg;

  localparam int K_MAX      = 16;
  localparam int VALUE_BITS = 12;
  localparam int COUNT_BITS = 16;
  localparam int CFG_BITS   = 5;
  localparam int K_BITS     = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int EXT_BITS   = $clog2(K_MAX + 1);
  localparam int VALUE_DEPTH = 1 << VALUE_BITS;
  localparam logic [CFG_BITS-1:0] TOP_COUNT_RST = CFG_BITS'(4);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  // handed from one cell to the next one down
  typedef struct packed {
    entry_t entry;
    logic   hi;    // this entry ranks above the incoming one
    logic   seen;  // incoming value found in this cell or above
  } link_t;

endpackage

FILE: design/stkf_if.sv
// Handshake interfaces for the input and result channels
interface stkf_in_if;
  logic                           valid;
  logic                           ready;
  logic [stkf_pkg::VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface stkf_out_if;
  logic                           valid;
  logic                           ready;
  logic [stkf_pkg::VALUE_BITS-1:0] ranked_value;
  logic [stkf_pkg::COUNT_BITS-1:0] ranked_count;
  logic                           last_of_list;

  modport source (output valid, output ranked_value, output ranked_count,
                  output last_of_list, input ready);
  modport sink   (input valid, input ranked_value, input ranked_count,
                  input last_of_list, output ready);
endinterface

FILE: design/stkf_ram.sv
// Generic single-write, single-read RAM with registered read data
module stkf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/stkf_cell.sv
// One slot of the ranked list: keeps, clears, takes the new entry or takes the one above
module stkf_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             upd,
  input  stkf_pkg::entry_t ins,
  input  stkf_pkg::link_t  prev,
  output stkf_pkg::link_t  next,
  output stkf_pkg::entry_t q
);

  stkf_pkg::entry_t entry_r;
  stkf_pkg::entry_t entry_nxt;
  logic             hi;
  logic             match;

  assign hi = (entry_r.count > ins.count) ||
              ((entry_r.count == ins.count) && (entry_r.value < ins.value));
  assign match = (entry_r.value == ins.value);

  always_comb begin
    entry_nxt = entry_r;
    if (clr) begin
      entry_nxt = '0;
    end else if (upd && !hi) begin
      if (prev.hi) begin
        entry_nxt = ins;
      end else if (!prev.seen) begin
        entry_nxt = prev.entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign next.entry = entry_r;
  assign next.hi    = hi;
  assign next.seen  = prev.seen | match;
  assign q          = entry_r;

endmodule

FILE: design/stream_top_k_frequency_tracker.sv
// Top level: streaming top-k frequency tracker
//
// in_ch carries one value per transaction; zero leaves the counts and the list
// alone but the list is still reported. Each value bumps a saturating count
// held in a 4096-entry RAM, and the value moves into its place in a ranked
// chain of K_MAX cells, kept in descending count order, smaller value first.
// out_ch then carries the nonempty ranked entries from the top, each with its
// count; last_of_list marks the final one. An empty list gives nothing.
// cfg_we/cfg_wdata write k (0 acts as 1, above K_MAX as K_MAX) and empty the
// list; counts are kept.
// Sequence: for a nonzero value the count read from the RAM is incremented in
// ST_RD and the chain is updated in ST_UPD; ST_EMIT then reads the chain out
// serially through the single output register, one result a cycle while the
// receiver does not stall. A new input is taken once the last result is in the
// output register, while it still waits there.
// A stalled receiver holds the output register and pauses the read-out.
// Reset empties the list, sets k to 4 and then clears the count RAM, one
// entry a cycle: in_ch.ready stays low until the whole RAM is cleared.
module stream_top_k_frequency_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  stkf_in_if.sink                       in_ch,
  stkf_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [stkf_pkg::CFG_BITS-1:0] cfg_wdata
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [stkf_pkg::VALUE_BITS-1:0] clr_addr_r, clr_addr_nxt;
  logic [stkf_pkg::VALUE_BITS-1:0] v_r, v_nxt;
  logic [stkf_pkg::COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [stkf_pkg::K_BITS-1:0]     idx_r, idx_nxt;
  logic [stkf_pkg::CFG_BITS-1:0]   top_count_r, top_count_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [stkf_pkg::VALUE_BITS-1:0] out_value_r, out_value_nxt;
  logic [stkf_pkg::COUNT_BITS-1:0] out_count_r, out_count_nxt;
  logic                            out_last_r, out_last_nxt;

  logic [stkf_pkg::EXT_BITS-1:0]   k_eff;
  logic [stkf_pkg::EXT_BITS-1:0]   idx_p1;
  logic                            is_last;
  logic                            out_free;
  logic                            in_acc;

  logic                            ram_we;
  logic [stkf_pkg::VALUE_BITS-1:0] ram_waddr;
  logic [stkf_pkg::COUNT_BITS-1:0] ram_wdata;
  logic [stkf_pkg::COUNT_BITS-1:0] ram_rdata;
  logic [stkf_pkg::COUNT_BITS-1:0] cnt_inc;

  stkf_pkg::entry_t ins;
  stkf_pkg::entry_t ents [stkf_pkg::K_MAX];
  stkf_pkg::link_t  lnk  [stkf_pkg::K_MAX+1];
  logic [stkf_pkg::VALUE_BITS-1:0] vals_ext [stkf_pkg::K_MAX+1];

  // effective k
  always_comb begin
    if (top_count_r == '0) begin
      k_eff = stkf_pkg::EXT_BITS'(1);
    end else if (int'(top_count_r) > stkf_pkg::K_MAX) begin
      k_eff = stkf_pkg::EXT_BITS'(stkf_pkg::K_MAX);
    end else begin
      k_eff = stkf_pkg::EXT_BITS'(top_count_r);
    end
  end

  // count RAM
  assign cnt_inc = (ram_rdata == stkf_pkg::COUNT_MAX) ? ram_rdata
                 : ram_rdata + stkf_pkg::COUNT_BITS'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = v_r;
    ram_wdata = cnt_r;
    if (state_r == ST_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (state_r == ST_UPD) begin
      ram_we    = 1'b1;
    end
  end

  stkf_ram #(
    .WIDTH (stkf_pkg::COUNT_BITS),
    .DEPTH (stkf_pkg::VALUE_DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_ch.value),
    .rdata (ram_rdata)
  );

  // ranked chain
  assign ins    = '{value: v_r, count: cnt_r};
  assign lnk[0] = '{entry: '0, hi: 1'b1, seen: 1'b0};

  for (genvar i = 0; i < stkf_pkg::K_MAX; i++) begin : g_cell
    stkf_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .clr   (cfg_we),
      .upd   ((state_r == ST_UPD) && (i < int'(k_eff))),
      .ins   (ins),
      .prev  (lnk[i]),
      .next  (lnk[i+1]),
      .q     (ents[i])
    );
    assign vals_ext[i] = ents[i].value;
  end
  assign vals_ext[stkf_pkg::K_MAX] = '0;

  // read-out
  assign idx_p1   = stkf_pkg::EXT_BITS'(idx_r) + stkf_pkg::EXT_BITS'(1);
  assign is_last  = (idx_p1 == k_eff) || (vals_ext[idx_p1] == '0);
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_acc   = in_ch.valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    v_nxt         = v_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    top_count_nxt = cfg_we ? cfg_wdata : top_count_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_value_nxt = out_value_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_CLR: begin
        clr_addr_nxt = clr_addr_r + stkf_pkg::VALUE_BITS'(1);
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          v_nxt   = in_ch.value;
          idx_nxt = '0;
          state_nxt = (in_ch.value == '0) ? ST_EMIT : ST_RD;
        end
      end
      ST_RD: begin
        cnt_nxt   = cnt_inc;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (ents[idx_r].value == '0) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = ents[idx_r].value;
          out_count_nxt = ents[idx_r].count;
          out_last_nxt  = is_last;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + stkf_pkg::K_BITS'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      idx_r       <= '0;
      top_count_r <= stkf_pkg::TOP_COUNT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      idx_r       <= idx_nxt;
      top_count_r <= top_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r         <= v_nxt;
    cnt_r       <= cnt_nxt;
    out_value_r <= out_value_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.ranked_value = out_value_r;
  assign out_ch.ranked_count = out_count_r;
  assign out_ch.last_of_list = out_last_r;

endmodule

FILE: design/stkf_checker.sv
// Port-level checker for the top-k frequency tracker, bound to the top level
`include "assert_macros.svh"

module stkf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [stkf_pkg::VALUE_BITS-1:0] out_ranked_value,
  input logic [stkf_pkg::COUNT_BITS-1:0] out_ranked_count,
  input logic                            out_last_of_list
);

  logic [stkf_pkg::VALUE_BITS+stkf_pkg::COUNT_BITS:0] out_payload;

  assign out_payload = {out_ranked_value, out_ranked_count, out_last_of_list};

  // a held result keeps its payload
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

  // one item at a time: no input right after an input transaction
  `ASSERT_NEXT(a_in_single, in_valid && in_ready, !in_ready)

  // reported entries are never empty
  `ASSERT_IMPLIES(a_out_nonempty, out_valid, (out_ranked_value != '0) && (out_ranked_count != '0))

  // the list of an item is finished before the next input is taken
  `ASSERT_ALWAYS(a_in_after_last, !(out_valid && !out_last_of_list && in_ready))

endmodule

bind stream_top_k_frequency_tracker stkf_checker u_stkf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_ranked_value (out_ch.ranked_value),
  .out_ranked_count (out_ch.ranked_count),
  .out_last_of_list (out_ch.last_of_list)
);

FILE: dv/testbench.sv
// Self-checking testbench for the streaming top-k frequency tracker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT  = 20000;
  localparam int unsigned SETTLE_CYC  = 10;

  typedef struct packed {
    logic [stkf_pkg::VALUE_BITS-1:0] value;
    logic [stkf_pkg::COUNT_BITS-1:0] count;
    logic                            last;
  } ranked_result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [stkf_pkg::CFG_BITS-1:0] cfg_wdata;

  stkf_in_if  in_if ();
  stkf_out_if out_if ();

  stream_top_k_frequency_tracker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [stkf_pkg::COUNT_BITS-1:0] tally [stkf_pkg::VALUE_DEPTH];
  logic [stkf_pkg::VALUE_BITS-1:0] slots [stkf_pkg::K_MAX+1];
  logic [stkf_pkg::CFG_BITS-1:0]   k_reg;

  logic [stkf_pkg::VALUE_BITS-1:0] pending_values [$];
  ranked_result_t                  expected_entries [$];

  bit          in_took;
  bit          out_took;
  bit          no_idle;
  int unsigned in_gap;
  int unsigned out_gap;
  int unsigned idle_cycles;
  int unsigned values_sent;
  int unsigned entries_checked;
  int unsigned settings_used;
  int unsigned mismatches;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int unsigned active_k();
    if (k_reg < 1) return 1;
    if (k_reg > stkf_pkg::K_MAX) return stkf_pkg::K_MAX;
    return 32'(k_reg);
  endfunction

  function automatic bit ranks_below(input int unsigned a);
    logic [stkf_pkg::COUNT_BITS-1:0] ca;
    logic [stkf_pkg::COUNT_BITS-1:0] cb;
    ca = tally[slots[a]];
    cb = tally[slots[a+1]];
    return (ca < cb) || ((ca == cb) && (slots[a] > slots[a+1]));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic apply_top_count(input logic [stkf_pkg::CFG_BITS-1:0] data);
    k_reg = data;
    for (int i = 0; i <= stkf_pkg::K_MAX; i++) slots[i] = '0;
    settings_used++;
  endtask

  task automatic tally_and_rank(input logic [stkf_pkg::VALUE_BITS-1:0] v);
    int unsigned                     k;
    int unsigned                     pos;
    int unsigned                     n;
    bit                              moving;
    logic [stkf_pkg::VALUE_BITS-1:0] t;
    ranked_result_t                  r;
    k = active_k();
    if (v != '0) begin
      if (tally[v] != stkf_pkg::COUNT_MAX) tally[v]++;
      slots[k] = v;
      pos = k;
      for (int i = 0; i < k; i++) if (slots[i] == v && pos == k) pos = i;
      moving = 1'b1;
      while (pos > 0 && moving) begin
        pos--;
        if (ranks_below(pos)) begin
          t           = slots[pos];
          slots[pos]  = slots[pos+1];
          slots[pos+1] = t;
        end else begin
          moving = 1'b0;
        end
      end
    end
    n = 0;
    while (n < k && slots[n] != '0) n++;
    for (int i = 0; i < n; i++) begin
      r.value = slots[i];
      r.count = tally[slots[i]];
      r.last  = (i == n - 1);
      expected_entries.push_back(r);
    end
  endtask

  // sampling, prediction, checking and watchdog
  always @(posedge clk) begin : observe
    ranked_result_t want;
    in_took  = 1'b0;
    out_took = 1'b0;
    if (rst_n) begin
      if (cfg_we) apply_top_count(cfg_wdata);
      if (in_if.valid && in_if.ready) begin
        in_took = 1'b1;
        values_sent++;
        tally_and_rank(in_if.value);
      end
      if (out_if.valid && out_if.ready) begin
        out_took = 1'b1;
        if (expected_entries.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: value %0d count %0d last %0b",
                     out_if.ranked_value, out_if.ranked_count, out_if.last_of_list);
        end else begin
          want = expected_entries.pop_front();
          entries_checked++;
          if (out_if.ranked_value !== want.value || out_if.ranked_count !== want.count ||
              out_if.last_of_list !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value %0d count %0d last %0b, got %0d %0d %0b",
                       want.value, want.count, want.last, out_if.ranked_value,
                       out_if.ranked_count, out_if.last_of_list);
          end
        end
      end
      if (in_took || out_took) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin : drive_in
    logic                            nv;
    logic [stkf_pkg::VALUE_BITS-1:0] nval;
    nv   = in_if.valid;
    nval = in_if.value;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        nv = 1'b0;
      end else if (pending_values.size() > 0) begin
        nval   = pending_values.pop_front();
        nv     = 1'b1;
        in_gap = pick_gap();
      end else begin
        nv = 1'b0;
      end
    end
    in_if.valid <= nv;
    in_if.value <= nval;
  end

  always @(negedge clk) begin : drive_out
    if (out_took) out_gap = pick_gap();
    if (out_gap > 0) begin
      out_gap--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic drain();
    while (pending_values.size() != 0 || in_if.valid || expected_entries.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_top_count(input logic [stkf_pkg::CFG_BITS-1:0] data);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic queue_random(input int unsigned n);
    logic [stkf_pkg::VALUE_BITS-1:0] pool [8];
    int unsigned                     pick;
    for (int i = 0; i < 8; i++) pool[i] = stkf_pkg::VALUE_BITS'($urandom_range(1, 4095));
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      pending_values.push_back(pool[$urandom_range(0, 7)]);
      else if (pick < 85)
        pending_values.push_back(stkf_pkg::VALUE_BITS'($urandom_range(1, 4095)));
      else if (pick < 93) pending_values.push_back('0);
      else if (pick < 96) pending_values.push_back(12'd1);
      else                pending_values.push_back(12'hFFF);
    end
  endtask

  task automatic queue_list(input logic [stkf_pkg::VALUE_BITS-1:0] vals [$]);
    foreach (vals[i]) pending_values.push_back(vals[i]);
  endtask

  initial begin : stimulus
    logic [stkf_pkg::VALUE_BITS-1:0] seq [$];
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    no_idle      = 1'b0;
    for (int i = 0; i < stkf_pkg::VALUE_DEPTH; i++) tally[i] = '0;
    for (int i = 0; i <= stkf_pkg::K_MAX; i++) slots[i] = '0;
    k_reg = stkf_pkg::TOP_COUNT_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty list first, then ties, overflow below the last slot, climbs and zeros
    seq = {12'd0, 12'd1, 12'hFFF, 12'd1, 12'd0, 12'd5, 12'd3, 12'd7, 12'd9, 12'd9,
           12'd9, 12'd9, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'h800, 12'h7FF,
           12'hAAA, 12'h555, 12'd0};
    queue_list(seq);

    write_top_count(5'd0);
    seq = {12'd2, 12'd2, 12'd6, 12'd6, 12'd6, 12'd0};
    queue_list(seq);

    write_top_count(5'd31);
    queue_random(40);

    write_top_count(5'd16);
    no_idle = 1'b1;
    queue_random(30);
    drain();
    no_idle = 1'b0;
    queue_random(30);

    write_top_count(5'($urandom_range(2, 15)));
    queue_random(20);
    drain();
    queue_random(20);

    // equal counts on fresh values, ordered by value
    write_top_count(5'd2);
    seq = {12'h0A5, 12'h05A, 12'd0, 12'h0A5, 12'h05A, 12'h123};
    queue_list(seq);

    write_top_count(5'd17);
    queue_random(15);

    write_top_count(5'($urandom_range(1, 31)));
    queue_random(15);

    drain();
    mismatches += expected_entries.size();
    $display("%0d values sent, %0d ranked entries checked over %0d list-size writes",
             values_sent, entries_checked, settings_used);
    $display("covered empty list, zero values, k limits and ties on equal counts");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/stkf_pkg.sv
design/stkf_if.sv
design/stkf_ram.sv
design/stkf_cell.sv
design/stream_top_k_frequency_tracker.sv
design/stkf_checker.sv
dv/testbench.sv
